FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the sorted index set.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/sis_pkg.sv
// Package for the sorted index set: sizes, opcodes, status codes and beat types.
// Depends on nothing; used by every module of the block.
package sis_pkg;

   localparam int CAPACITY = 32;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Opcodes of a request beat.
   localparam logic [2:0] OP_INSERT        = 3'd0;
   localparam logic [2:0] OP_INSERT_UNIQUE = 3'd1;
   localparam logic [2:0] OP_REMOVE        = 3'd2;
   localparam logic [2:0] OP_CONTAINS      = 3'd3;
   localparam logic [2:0] OP_CLEAR         = 3'd4;

   // Status codes of a response beat.
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [VALUE_W-1:0] index_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [5:0] entry_count;
   } rsp_type;

   // Commands broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic search;       // compare the held entry against the key
      logic ins_after;    // insert the key after all equal entries
      logic ins_before;   // insert the key before all equal entries
      logic remove;       // remove the first equal entry, close the gap
      logic clear;        // mark every cell empty
   } cell_ctrl_type;

endpackage

FILE: hdl/sis_cell.sv
// One cell of the sorted row: holds a single entry, its occupied flag and the
// compare flags of the last search. Depends on sis_pkg.
module sis_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  sis_pkg::cell_ctrl_type      ctrl,
   input  logic [sis_pkg::VALUE_W-1:0] key,
   input  logic [sis_pkg::VALUE_W-1:0] prev_value,
   input  logic                        prev_occ,
   input  logic                        prev_before,
   input  logic [sis_pkg::VALUE_W-1:0] next_value,
   input  logic                        next_occ,
   output logic [sis_pkg::VALUE_W-1:0] value,
   output logic                        occ,
   output logic                        eq,
   output logic                        keep_place
);
   import sis_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               occ_ff, occ_in;
   logic               lt_ff, eq_ff;

   assign value = value_ff;
   assign occ   = occ_ff;
   assign eq    = eq_ff;

   // The insertion point lies after this cell when this cell stays in place.
   assign keep_place = ctrl.ins_after ? (lt_ff | eq_ff) : lt_ff;

   // Search phase: register where this entry sits relative to the key.
   always_ff @(posedge clock) begin
      if (ctrl.search) begin
         lt_ff <= occ_ff && (value_ff < key);
         eq_ff <= occ_ff && (value_ff == key);
      end
   end

   // Apply phase: keep, take the key, or take a neighbour's entry.
   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.ins_after || ctrl.ins_before) begin
         if (!prev_before) begin
            value_in = prev_value;
            occ_in   = prev_occ;
         end else if (!keep_place) begin
            value_in = key;
            occ_in   = 1'b1;
         end
      end else if (ctrl.remove) begin
         if (!lt_ff) begin
            value_in = next_value;
            occ_in   = next_occ;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

FILE: hdl/sorted_index_set_top.sv
// Sorted index set: a row of compare-and-shift cells under a small controller.
// A request beat is accepted into the search phase, where the search flags are registered; in the
// apply phase the table is changed and the response registered, once the response register is free.
// A new request is taken in the apply cycle whenever the response register is free.
// Reset empties the table and the response register; no clearing pass is needed.
module sorted_index_set_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sis_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sis_pkg::rsp_type rsp_data
);
   import sis_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SEARCH = 3'b010,
      PH_APPLY  = 3'b100
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [2:0]         op_ff;
   logic [VALUE_W-1:0] key_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   cell_ctrl_type      ctrl;

   logic [VALUE_W-1:0] cell_value  [CAPACITY];
   logic [CAPACITY-1:0] cell_occ, cell_eq, cell_before;

   logic slot_free, go, req_fire, present, full;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign go        = (phase_ff == PH_APPLY) && slot_free;
   assign req_ready = (phase_ff == PH_IDLE) || go;
   assign req_fire  = req_valid && req_ready;
   assign present   = |cell_eq;
   assign full      = (count_ff == COUNT_W'(CAPACITY));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decide the operation and the response from the registered search flags.
   always_comb begin
      ctrl               = '0;
      ctrl.search        = (phase_ff == PH_SEARCH);
      count_in           = count_ff;
      rsp_in.status      = ST_DONE;
      rsp_in.found       = present;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.ins_after = go;
               count_in       = count_ff + 1'b1;
            end
         end
         OP_INSERT_UNIQUE: begin
            if (present) begin
               rsp_in.status = ST_DUPLICATE;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.ins_before = go;
               count_in        = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (present) begin
               ctrl.remove = go;
               count_in    = count_ff - 1'b1;
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         OP_CONTAINS: begin
            if (!present) begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         OP_CLEAR: begin
            ctrl.clear   = go;
            count_in     = '0;
            rsp_in.found = 1'b0;
         end
         default: begin
            rsp_in.found = 1'b0;
         end
      endcase
      rsp_in.entry_count = 6'(count_in);
   end

   // Phase sequencing.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE:   if (req_fire) phase_in = PH_SEARCH;
         PH_SEARCH: phase_in = PH_APPLY;
         PH_APPLY: begin
            if (go) begin
               phase_in = req_fire ? PH_SEARCH : PH_IDLE;
            end
         end
         default:   phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_data.opcode;
         key_ff <= req_data.index_value;
      end
      if (go) begin
         rsp_ff <= rsp_in;
      end
   end

   // The row of cells, each linked to its neighbours; the head cell takes the key from its previous side.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] prev_value, next_value;
      logic               prev_occ, prev_before, next_occ;

      if (i == 0) begin : g_head
         assign prev_value  = key_ff;
         assign prev_occ    = 1'b1;
         assign prev_before = 1'b1;
      end else begin : g_body
         assign prev_value  = cell_value[i-1];
         assign prev_occ    = cell_occ[i-1];
         assign prev_before = cell_before[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_occ   = 1'b0;
      end else begin : g_inner
         assign next_value = cell_value[i+1];
         assign next_occ   = cell_occ[i+1];
      end

      sis_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key_ff),
         .prev_value  (prev_value),
         .prev_occ    (prev_occ),
         .prev_before (prev_before),
         .next_value  (next_value),
         .next_occ    (next_occ),
         .value       (cell_value[i]),
         .occ         (cell_occ[i]),
         .eq          (cell_eq[i]),
         .keep_place  (cell_before[i])
      );
   end

endmodule

FILE: hdl/sis_checker.sv
// Port-level checker for the sorted index set, bound to the top level.
// Depends on sis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sis_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sis_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sis_pkg::rsp_type rsp_data
);
   import sis_pkg::*;

   // A stalled response beat holds its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // After a request beat the block searches and takes no new request while it does.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // A rejected duplicate was necessarily present.
   `ASSERT_SAME(a_dup_found, clock, reset, rsp_valid && rsp_data.status == ST_DUPLICATE, rsp_data.found)

   // A miss never reports the value as found.
   `ASSERT_SAME(a_miss_clean, clock, reset, rsp_valid && rsp_data.status == ST_NOT_FOUND, !rsp_data.found)

endmodule

bind sorted_index_set_top sis_checker u_sis_checker (.*);
